// File: sv/sma_pkg.sv
// sma_pkg: shared types and constants for the moving-average crossover block
// used by sma_cell, sma_chain and sma_crossover_delta; no dependencies
package sma_pkg;

  // sample word as it sits in the delay cells
  localparam int SAMPLE_W = 32;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // configuration register widths and reset values
  localparam int SHORT_W   = 8;
  localparam int LONG_W    = 9;
  localparam int CFG_IDX_W = 8;

  localparam logic [SHORT_W-1:0] SHORT_RST = SHORT_W'(5);
  localparam logic [LONG_W-1:0]  LONG_RST  = LONG_W'(20);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHORT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LONG  = CFG_IDX_W'(1);

endpackage

// File: sv/sma_crossover_delta.sv
// sma_crossover_delta: top level of the moving-average crossover difference block
// depends on sma_pkg, sma_chain (sma_cell) and sma_div
//
// Each input word carries one signed Q16.16 sample; samples flagged missing and
// exact zeros are skipped. Accepted samples run down two cell chains, one per
// window, whose load points follow the configured periods so the sample leaving
// each window always appears at the chain tail. Exact running sums are kept, and
// once the long window is full every accepted sample yields short mean minus
// long mean, rounded to nearest (ties away from zero) and saturated. One result
// word per input word. A skipped word or one taken before the long window is
// full, bypasses the divider. A word that yields a valid delta passes the
// multiply, subtract and bit-serial divide steps, dividing by short_period *
// long_period, and no new word is taken until its result is registered. Any write
// of a known register clears both windows. No clearing pass follows reset.
module sma_crossover_delta #(
  parameter int MAX_PERIOD = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // [31:0] sample
  input  logic [0:0]                     in_tuser,   // [0] sample_missing
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // [31:0] delta
  output logic [0:0]                     out_tuser,  // [0] delta_valid
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sma_pkg::LONG_W-1:0]     cfg_data
);
  import sma_pkg::*;

  localparam int PW   = $clog2(MAX_PERIOD + 1);
  localparam int EW   = (PW > LONG_W) ? PW : LONG_W;
  localparam int SUMW = SAMPLE_W + PW;
  localparam int NUMW = SUMW + PW + 1;
  localparam int DENW = 2 * PW;
  localparam int DVW  = NUMW;

  localparam logic [EW-1:0]  MAXP_E  = EW'(MAX_PERIOD);
  localparam logic [DVW-1:0] NEG_LIM = DVW'(64'd2147483648);
  localparam logic [DVW-1:0] POS_LIM = DVW'(64'd2147483647);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_SUB   = 6'b000100,
    S_START = 6'b001000,
    S_DIV   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [SHORT_W-1:0]      short_period_r;
  logic [LONG_W-1:0]       long_period_r;
  logic [PW-1:0]           count_r;
  logic signed [SUMW-1:0]  short_sum_r, short_sum_nxt;
  logic signed [SUMW-1:0]  long_sum_r, long_sum_nxt;
  logic signed [NUMW-1:0]  prod_s_r, prod_l_r;
  logic signed [NUMW-1:0]  num_r;
  logic [DENW-1:0]         den_r;
  logic                    out_valid_r;
  logic [31:0]             delta_r;
  logic                    delta_valid_r;

  logic [EW-1:0]           lp_e, sp_e, eff_l_e, eff_s_e;
  logic [PW-1:0]           eff_l, eff_s, load_s, load_l;
  logic                    cfg_wr, cfg_clear;
  logic                    in_acc, take, out_free;
  logic [PW-1:0]           count_inc;
  logic                    drop_s, drop_l, goes_valid;
  sample_t                 sample_in, tail_s, tail_l;
  logic signed [SUMW-1:0]  x_ext;
  logic [DVW-1:0]          half_e, dividend;
  logic                    div_start, div_done;
  logic [DVW-1:0]          div_quo;
  logic [31:0]             sat_delta;

  // effective periods: long clamped to 1..MAX_PERIOD, short to 1..long
  always_comb begin
    lp_e    = EW'(long_period_r);
    sp_e    = EW'(short_period_r);
    eff_l_e = (lp_e == '0) ? EW'(1) : ((lp_e > MAXP_E) ? MAXP_E : lp_e);
    eff_s_e = (sp_e == '0) ? EW'(1) : ((sp_e > eff_l_e) ? eff_l_e : sp_e);
    eff_l   = eff_l_e[PW-1:0];
    eff_s   = eff_s_e[PW-1:0];
    load_s  = PW'(MAX_PERIOD) - eff_s;
    load_l  = PW'(MAX_PERIOD) - eff_l;
  end

  // handshakes
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign cfg_clear = cfg_wr & ((cfg_index == REG_SHORT) || (cfg_index == REG_LONG));
  assign out_free  = ~out_valid_r | out_tready;
  assign in_tready = (state_r == S_IDLE) & out_free;
  assign in_acc    = in_tvalid & in_tready;
  assign sample_in = $signed(in_tdata);
  assign take      = ~in_tuser[0] & (in_tdata != '0);

  // window delay chains, one per period
  sma_chain #(.N(MAX_PERIOD), .PW(PW)) u_chain_s (
    .clk      (clk),
    .shift_en (in_acc & take),
    .load_pt  (load_s),
    .din      (sample_in),
    .tail     (tail_s)
  );

  sma_chain #(.N(MAX_PERIOD), .PW(PW)) u_chain_l (
    .clk      (clk),
    .shift_en (in_acc & take),
    .load_pt  (load_l),
    .din      (sample_in),
    .tail     (tail_l)
  );

  // running sums and fill count
  always_comb begin
    x_ext         = SUMW'(sample_in);
    drop_s        = (count_r >= eff_s);
    drop_l        = (count_r >= eff_l);
    short_sum_nxt = short_sum_r - (drop_s ? SUMW'(tail_s) : SUMW'(0)) + x_ext;
    long_sum_nxt  = long_sum_r - (drop_l ? SUMW'(tail_l) : SUMW'(0)) + x_ext;
    count_inc     = (count_r < eff_l) ? PW'(count_r + 1'b1) : eff_l;
    goes_valid    = take & (count_inc >= eff_l);
  end

  // rounding offset and magnitude of the numerator
  always_comb begin
    half_e   = DVW'(den_r[DENW-1:1]);
    dividend = num_r[NUMW-1] ? (half_e - DVW'(num_r)) : (DVW'(num_r) + half_e);
  end

  assign div_start = (state_r == S_START);

  sma_div #(.DVW(DVW), .DENW(DENW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sign and saturation of the rounded quotient
  always_comb begin
    if (num_r[NUMW-1]) begin
      sat_delta = (div_quo > NEG_LIM) ? 32'h8000_0000 : (32'd0 - div_quo[31:0]);
    end else begin
      sat_delta = (div_quo > POS_LIM) ? 32'h7FFF_FFFF : div_quo[31:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && goes_valid) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_SUB;
      S_SUB:   state_nxt = S_START;
      S_START: state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      short_period_r <= SHORT_RST;
      long_period_r  <= LONG_RST;
      count_r        <= '0;
      short_sum_r    <= '0;
      long_sum_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && cfg_index == REG_SHORT) begin
        short_period_r <= cfg_data[SHORT_W-1:0];
      end
      if (cfg_wr && cfg_index == REG_LONG) begin
        long_period_r <= cfg_data;
      end
      if (cfg_clear) begin
        count_r     <= '0;
        short_sum_r <= '0;
        long_sum_r  <= '0;
      end else if (in_acc && take) begin
        count_r     <= count_inc;
        short_sum_r <= short_sum_nxt;
        long_sum_r  <= long_sum_nxt;
      end
      if ((in_acc && !goes_valid) || (state_r == S_DONE && out_free)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // arithmetic and result registers
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      prod_s_r <= NUMW'(short_sum_r) * NUMW'({1'b0, eff_l});
      prod_l_r <= NUMW'(long_sum_r) * NUMW'({1'b0, eff_s});
      den_r    <= DENW'(eff_s) * DENW'(eff_l);
    end
    if (state_r == S_SUB) begin
      num_r <= prod_s_r - prod_l_r;
    end
    if (in_acc && !goes_valid) begin
      delta_r       <= '0;
      delta_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      delta_r       <= sat_delta;
      delta_valid_r <= 1'b1;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = delta_r;
  assign out_tuser[0] = delta_valid_r;

  // fill count never passes the long window
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= eff_l)
    else $error("fill count above long period");

  // a register write empties both windows
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_clear |=> (count_r == '0) && (short_sum_r == '0) && (long_sum_r == '0))
    else $error("window not cleared after config write");

  // the divider only finishes while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider done outside divide state");

  // an invalid result word carries a zero delta
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> out_tdata == '0)
    else $error("invalid result with nonzero delta");

endmodule

// File: sv/sma_cell.sv
// sma_cell: one stage of the sample delay chain
// depends on sma_pkg for sample_t
module sma_cell #(
  parameter int IDX = 0,
  parameter int PW  = 9
) (
  input  logic            clk,
  input  logic            shift_en,
  input  logic [PW-1:0]   load_pt,
  input  sma_pkg::sample_t din_new,
  input  sma_pkg::sample_t din_prev,
  output sma_pkg::sample_t dout
);
  import sma_pkg::*;

  sample_t data_r;
  sample_t data_nxt;

  // a new sample enters at the load point, every other cell takes its neighbor
  always_comb begin
    data_nxt = (load_pt == PW'(IDX)) ? din_new : din_prev;
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= data_nxt;
    end
  end

  assign dout = data_r;

endmodule

// File: sv/sma_chain.sv
// sma_chain: row of sma_cell stages forming a variable-length sample delay
// depends on sma_pkg and sma_cell; the oldest sample leaves at the fixed tail
module sma_chain #(
  parameter int N  = 256,
  parameter int PW = 9
) (
  input  logic             clk,
  input  logic             shift_en,
  input  logic [PW-1:0]    load_pt,
  input  sma_pkg::sample_t din,
  output sma_pkg::sample_t tail
);
  import sma_pkg::*;

  sample_t cell_out [N];

  // cell i hands its sample to cell i+1 on every accepted word
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      sma_cell #(.IDX(i), .PW(PW)) u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .load_pt  (load_pt),
        .din_new  (din),
        .din_prev (din),
        .dout     (cell_out[i])
      );
    end else begin : g_body
      sma_cell #(.IDX(i), .PW(PW)) u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .load_pt  (load_pt),
        .din_new  (din),
        .din_prev (cell_out[i-1]),
        .dout     (cell_out[i])
      );
    end
  end

  assign tail = cell_out[N-1];

endmodule

// File: sv/sma_div.sv
// sma_div: bit-serial restoring divider, one quotient bit per cycle
// no package dependencies; divisor must be nonzero
module sma_div #(
  parameter int DVW  = 51,
  parameter int DENW = 18
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DVW-1:0]  dividend,
  input  logic [DENW-1:0] divisor,
  output logic            done,
  output logic [DVW-1:0]  quotient
);

  localparam int CNTW = (DVW > 1) ? $clog2(DVW) : 1;

  logic [DVW-1:0]  dvd_r, dvd_nxt;
  logic [DENW-1:0] dvs_r;
  logic [DENW-1:0] rem_r, rem_nxt;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [DENW:0]   shifted;
  logic [DENW+1:0] trial;
  logic            ge;

  // trial subtract of the divisor from the partial remainder
  always_comb begin
    shifted = {rem_r, dvd_r[DVW-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_r};
    ge      = ~trial[DENW+1];
    rem_nxt = ge ? trial[DENW-1:0] : shifted[DENW-1:0];
    dvd_nxt = {dvd_r[DVW-2:0], ge};
  end

  // control: busy while the quotient bits shift in, then a done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(DVW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend register shifts into the quotient
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// File: test/testbench.sv
// testbench: self-checking bench for sma_crossover_delta, moving-average crossover
// depends on sma_pkg and the sma_crossover_delta rtl; holds its own window model
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sma_pkg::*;

  localparam int MAX_PER    = 256;
  localparam int QUIET_MAX  = 4000;
  localparam int HOLD_AT    = 750;
  localparam int HOLD_LEN   = 600;
  localparam int DRAIN_WAIT = 120;
  // register indexes outside the register list
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = '1;

  typedef struct {
    logic [31:0] sample;
    logic        missing;
  } sample_word_t;

  typedef struct {
    logic [31:0] delta;
    logic        valid;
  } delta_word_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  // block ports
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata = '0;
  logic [0:0]           in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;
  logic [0:0]           out_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LONG_W-1:0]    cfg_data = '0;

  sma_crossover_delta #(.MAX_PERIOD(MAX_PER)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [31:0] sample
    .in_tuser   (in_tuser),   // [0] sample_missing
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [31:0] delta
    .out_tuser  (out_tuser),  // [0] delta_valid
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // pending samples and expected deltas
  sample_word_t sample_queue[$];
  delta_word_t  delta_queue[$];
  int n_sent = 0;
  int n_errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // window model state
  logic [SHORT_W-1:0] per_short = SHORT_RST;
  logic [LONG_W-1:0]  per_long = LONG_RST;
  longint win_ring[MAX_PER];
  int     win_wp = 0;
  int     win_count = 0;
  longint sum_short = 0;
  longint sum_long = 0;

  function automatic void clear_window();
    win_wp = 0;
    win_count = 0;
    sum_short = 0;
    sum_long = 0;
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [LONG_W-1:0] data);
    if (idx == REG_SHORT) begin
      per_short = data[SHORT_W-1:0];
      clear_window();
    end else if (idx == REG_LONG) begin
      per_long = data;
      clear_window();
    end
  endfunction

  // advance the windows by one word and work out its delta
  function automatic delta_word_t crossover_delta(sample_word_t w);
    delta_word_t res;
    longint x, num, len_l, len_s, den, mag, q;
    int len_long, len_short;
    logic neg;
    res.delta = '0;
    res.valid = 1'b0;
    x = longint'($signed(w.sample));
    len_long = int'(per_long);
    if (len_long < 1) len_long = 1;
    if (len_long > MAX_PER) len_long = MAX_PER;
    len_short = int'(per_short);
    if (len_short < 1) len_short = 1;
    if (len_short > len_long) len_short = len_long;
    if (!w.missing && x != 0) begin
      // drop the samples leaving each window
      if (win_count >= len_short)
        sum_short -= win_ring[(win_wp + MAX_PER - len_short) % MAX_PER];
      if (win_count >= len_long)
        sum_long -= win_ring[(win_wp + MAX_PER - len_long) % MAX_PER];
      sum_short += x;
      sum_long += x;
      win_ring[win_wp] = x;
      win_wp = (win_wp + 1) % MAX_PER;
      if (win_count < len_long) win_count++;
      if (win_count >= len_long) begin
        // exact difference, round half away from zero, saturate
        len_l = longint'(len_long);
        len_s = longint'(len_short);
        num = sum_short * len_l - sum_long * len_s;
        den = len_s * len_l;
        neg = (num < 0);
        mag = neg ? -num : num;
        q = (mag + den / 2) / den;
        if (neg) res.delta = (q > 64'sh80000000) ? 32'h80000000 : 32'(-q);
        else res.delta = (q > 64'sh7FFFFFFF) ? 32'h7FFFFFFF : 32'(q);
        res.valid = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    n_errors++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        delta_queue.insert(delta_queue.size(), crossover_delta(sample_queue[0]));
        sample_queue.delete(0);
        n_sent <= n_sent + 1;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= sample_queue[0].sample;
          in_tuser <= sample_queue[0].missing;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off to back the block up
  int  hold_left = 0;
  logic hold_used = 1'b0;
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_used && n_sent >= HOLD_AT) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_LEN;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // result monitor
  delta_word_t want;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (delta_queue.size() == 0) begin
        report_mismatch("unexpected word", out_tdata, '0);
      end else begin
        want = delta_queue[0];
        delta_queue.delete(0);
        if (out_tdata !== want.delta) report_mismatch("delta", out_tdata, want.delta);
        if (out_tuser[0] !== want.valid)
          report_mismatch("delta_valid", 32'(out_tuser), 32'(want.valid));
      end
    end
  end

  // watchdog on cycles with no handshake at all
  int quiet = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("sma_crossover_delta test failed");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (sample_queue.size() != 0 || delta_queue.size() != 0 || in_tvalid)
      @(negedge clk);
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [LONG_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg_write(idx, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_periods(logic [LONG_W-1:0] s, logic [LONG_W-1:0] l);
    reg_write(REG_SHORT, s);
    reg_write(REG_LONG, l);
  endtask

  task automatic push_word(logic [31:0] s, logic m);
    sample_word_t w;
    w.sample = s;
    w.missing = m;
    sample_queue.insert(sample_queue.size(), w);
  endtask

  // random samples: mostly accepted values, some skips and extremes
  task automatic run_random(int n);
    int pick;
    @(negedge clk);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) push_word($urandom, 1'b1);
      else if (pick < 12) push_word('0, 1'b0);
      else if (pick < 20) push_word($urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000, 1'b0);
      else if (pick < 50) push_word(32'($urandom_range(0, 2097152)) - 32'd1048576, 1'b0);
      else push_word($urandom, 1'b0);
    end
    wait_idle();
  endtask

  task automatic set_idle(int send_pct, int recv_pct);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // stimulus
  initial begin
    int s;
    foreach (win_ring[i]) win_ring[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    set_idle(34, 54);

    // reset values of both periods
    run_random(150);

    // one- and two-sample windows: extremes, saturation, rounding ties, skips
    set_periods(9'd1, 9'd2);
    @(negedge clk);
    push_word(32'h7FFFFFFF, 1'b0);
    push_word(32'h80000000, 1'b0);
    push_word(32'h7FFFFFFF, 1'b0);
    push_word(32'h80000000, 1'b0);
    push_word(32'h00000000, 1'b0);
    push_word(32'h12345678, 1'b1);
    push_word(32'h00000000, 1'b1);
    push_word(32'h00000001, 1'b0);
    push_word(32'h00000002, 1'b0);
    push_word(32'h00000001, 1'b0);
    push_word(32'hFFFFFFFF, 1'b0);
    push_word(32'h7FFFFFFF, 1'b1);
    push_word(32'h80000000, 1'b1);
    push_word(32'h00010000, 1'b0);
    push_word(32'hFFFF0000, 1'b0);
    push_word(32'h00000003, 1'b0);
    push_word(32'hFFFFFFFD, 1'b0);
    wait_idle();

    // zero periods act as one
    set_periods(9'd0, 9'd0);
    run_random(60);

    // writes to unknown indexes leave the window alone
    set_periods(9'd3, 9'd8);
    run_random(40);
    reg_write(REG_UNUSED, 9'h1FF);
    reg_write(REG_TOP, 9'h000);
    run_random(160);

    set_idle(54, 34);
    // widest windows
    set_periods(9'd255, 9'd256);
    run_random(400);

    // long above the maximum, short data wider than its register
    set_periods(9'h10A, 9'h1FF);
    run_random(350);

    // short above long clamps to long
    set_periods(9'd10, 9'd7);
    run_random(150);

    set_idle(0, 0);
    set_periods(9'd2, 9'd3);
    run_random(150);
    repeat (3) begin
      s = $urandom_range(1, 20);
      set_periods(9'(s), 9'($urandom_range(s + 1, 40)));
      run_random(150);
    end

    // drain and finish
    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_errors == 0) begin
      $display("sma_crossover_delta test passed");
    end else begin
      $display("sma_crossover_delta test failed");
    end
    $finish;
  end

endmodule

// File: sma_crossover_delta.f
sv/sma_pkg.sv
sv/sma_cell.sv
sv/sma_chain.sv
sv/sma_div.sv
sv/sma_crossover_delta.sv
test/testbench.sv
